FILE: hdl/i2cm_pkg.sv
package i2cm_pkg;

   localparam int unsigned CfgWidth = 16;

   localparam logic [CfgWidth-1:0] HALF_PERIOD_RESET = 16'd4;
   localparam logic [CfgWidth-1:0] ACK_TIMEOUT_RESET = 16'd250;

   // configuration register indexes
   localparam logic CSR_HALF_PERIOD = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   // item codes
   localparam logic [2:0] MODE_TICK     = 3'd0;
   localparam logic [2:0] MODE_START    = 3'd1;
   localparam logic [2:0] MODE_STOP     = 3'd2;
   localparam logic [2:0] MODE_WRITE    = 3'd3;
   localparam logic [2:0] MODE_READ     = 3'd4;
   localparam logic [2:0] MODE_WAIT_ACK = 3'd5;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_error;
   } result_type;

endpackage

FILE: hdl/i2cm_seq.sv
module i2cm_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [2:0]                    mode,
   input  logic [7:0]                    tx_byte,
   input  logic                          ack_to_send,
   input  logic                          sda_sample,
   input  logic [i2cm_pkg::CfgWidth-1:0] half_period_ticks,
   input  logic [i2cm_pkg::CfgWidth-1:0] ack_timeout_ticks,
   output i2cm_pkg::result_type          result
);
   import i2cm_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_WA1, PH_WA2, PH_WAP,
      PH_WRA, PH_WRB, PH_WRC, PH_RDL, PH_RDH, PH_AK1, PH_AK2
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic                read_ack_ff, read_ack_in;
   logic [3:0]          bit_index_ff, bit_index_in;
   logic [7:0]          shift_ff, shift_in;
   logic [CfgWidth-1:0] delay_ff, delay_in;
   logic [CfgWidth-1:0] timeout_ff, timeout_in;
   logic                scl_ff, scl_in;
   logic                sda_ff, sda_in;
   logic                drive_ff, drive_in;
   logic                error_ff, error_in;
   logic [7:0]          rx_hold_ff, rx_hold_in;
   logic                done;

   logic [CfgWidth-1:0] load_delay;
   logic [CfgWidth-1:0] delay_dec;
   logic [3:0]          index_inc;
   logic [7:0]          shift_rx;

   assign load_delay = (half_period_ticks == '0) ? CfgWidth'(1) : half_period_ticks;
   assign delay_dec  = (delay_ff != '0) ? delay_ff - CfgWidth'(1) : '0;
   assign index_inc  = bit_index_ff + 4'd1;
   assign shift_rx   = {shift_ff[6:0], sda_sample};

   always_comb begin
      phase_in     = phase_ff;
      read_ack_in  = read_ack_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      delay_in     = delay_ff;
      timeout_in   = timeout_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      drive_in     = drive_ff;
      error_in     = error_ff;
      rx_hold_in   = rx_hold_ff;
      done         = 1'b0;

      if (mode != MODE_TICK && phase_ff == PH_IDLE) begin
         bit_index_in = 4'd0;
         delay_in     = load_delay;
         case (mode)
            MODE_START: begin
               scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b1;
               phase_in = PH_ST1;
            end
            MODE_STOP: begin
               scl_in = 1'b0; sda_in = 1'b0; drive_in = 1'b1;
               phase_in = PH_SP1;
            end
            MODE_WRITE: begin
               shift_in = tx_byte;
               scl_in = 1'b0; sda_in = tx_byte[7]; drive_in = 1'b1;
               phase_in = PH_WRA;
            end
            MODE_READ: begin
               read_ack_in = ack_to_send;
               shift_in = 8'd0;
               scl_in = 1'b0; sda_in = 1'b1; drive_in = 1'b0;
               phase_in = PH_RDL;
            end
            MODE_WAIT_ACK: begin
               error_in = 1'b0;
               timeout_in = '0;
               sda_in = 1'b1; drive_in = 1'b0;
               phase_in = PH_WA1;
            end
            default: begin
               // unused codes leave everything untouched
               bit_index_in = bit_index_ff;
               delay_in     = delay_ff;
            end
         endcase
      end else if (mode == MODE_TICK && phase_ff == PH_WAP) begin
         if (!sda_sample) begin
            scl_in = 1'b0;
            phase_in = PH_IDLE; delay_in = '0; done = 1'b1;
         end else if (timeout_ff >= ack_timeout_ticks) begin
            error_in = 1'b1;
            scl_in = 1'b0; sda_in = 1'b0; drive_in = 1'b1;
            phase_in = PH_SP1; delay_in = load_delay;
         end else begin
            timeout_in = timeout_ff + CfgWidth'(1);
         end
      end else if (mode == MODE_TICK && phase_ff != PH_IDLE) begin
         delay_in = delay_dec;
         if (delay_dec == '0) begin
            delay_in = load_delay;
            case (phase_ff)
               PH_ST1: begin
                  scl_in = 1'b1; sda_in = 1'b0; drive_in = 1'b1;
                  phase_in = PH_ST2;
               end
               PH_ST2: begin
                  scl_in = 1'b0; sda_in = 1'b0; drive_in = 1'b1;
                  phase_in = PH_IDLE; delay_in = '0; done = 1'b1;
               end
               PH_SP1: begin
                  scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b1;
                  phase_in = PH_SP2;
               end
               PH_WA1: begin
                  scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b0;
                  phase_in = PH_WA2;
               end
               PH_WA2: begin
                  // polling starts, delay counter left at zero
                  phase_in = PH_WAP; delay_in = '0; timeout_in = '0;
               end
               PH_WRA: begin
                  scl_in = 1'b1; drive_in = 1'b1;
                  phase_in = PH_WRB;
               end
               PH_WRB: begin
                  scl_in = 1'b0; drive_in = 1'b1;
                  phase_in = PH_WRC;
               end
               PH_WRC: begin
                  bit_index_in = index_inc;
                  if (index_inc >= 4'd8) begin
                     phase_in = PH_IDLE; delay_in = '0; done = 1'b1;
                  end else begin
                     scl_in = 1'b0; drive_in = 1'b1;
                     sda_in = shift_ff[3'd7 - index_inc[2:0]];
                     phase_in = PH_WRA;
                  end
               end
               PH_RDL: begin
                  scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b0;
                  phase_in = PH_RDH;
               end
               PH_RDH: begin
                  shift_in = shift_rx;
                  bit_index_in = index_inc;
                  if (index_inc >= 4'd8) begin
                     rx_hold_in = shift_rx;
                     scl_in = 1'b0; sda_in = !read_ack_ff; drive_in = 1'b1;
                     phase_in = PH_AK1;
                  end else begin
                     scl_in = 1'b0; sda_in = 1'b1; drive_in = 1'b0;
                     phase_in = PH_RDL;
                  end
               end
               PH_AK1: begin
                  scl_in = 1'b1; drive_in = 1'b1;
                  phase_in = PH_AK2;
               end
               PH_AK2: begin
                  scl_in = 1'b0; drive_in = 1'b1;
                  phase_in = PH_IDLE; delay_in = '0; done = 1'b1;
               end
               default: begin
                  // stop tail and anything unexpected end the command
                  phase_in = PH_IDLE; delay_in = '0; done = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      result.scl_level = scl_in;
      result.sda_level = sda_in;
      result.sda_drive = drive_in;
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.rx_byte   = rx_hold_in;
      result.ack_error = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         read_ack_ff  <= 1'b0;
         bit_index_ff <= 4'd0;
         shift_ff     <= 8'd0;
         delay_ff     <= '0;
         timeout_ff   <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         drive_ff     <= 1'b1;
         error_ff     <= 1'b0;
         rx_hold_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         read_ack_ff  <= read_ack_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         delay_ff     <= delay_in;
         timeout_ff   <= timeout_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         drive_ff     <= drive_in;
         error_ff     <= error_in;
         rx_hold_ff   <= rx_hold_in;
      end
   end

   a_start_enters: assert property (@(posedge clock) disable iff (reset)
      accept && mode == MODE_START && phase_ff == PH_IDLE |=> phase_ff == PH_ST1)
      else $error("start command did not enter its first phase");

   a_released_high: assert property (@(posedge clock) disable iff (reset)
      !drive_ff |-> sda_ff)
      else $error("released sda not shown high");

   a_idle_no_delay: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> delay_ff == '0)
      else $error("delay counter left running while idle");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= 4'd8)
      else $error("bit index past eight");

endmodule

FILE: hdl/i2cm_rsp_buf.sv
module i2cm_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  i2cm_pkg::result_type in_data,
   output logic                 in_stall,
   output logic                 out_valid,
   input  logic                 out_stall,
   output i2cm_pkg::result_type out_data
);
   import i2cm_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = main_valid_ff && !out_stall;
   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         main_valid_in = 1'b0;
      end
      if (skid_valid_ff && pop) begin
         main_in       = skid_ff;
         main_valid_in = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (in_valid && !skid_valid_ff) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            // output beat still held, park the new one
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage holds a beat with the output stage empty");

   a_blocked_to_skid: assert property (@(posedge clock) disable iff (reset)
      in_valid && !skid_valid_ff && main_valid_ff && out_stall |=> skid_valid_ff)
      else $error("beat accepted behind a stalled output was lost");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      pop && !skid_valid_ff && !in_valid |=> !main_valid_ff)
      else $error("output beat repeated after it was taken");

endmodule

FILE: hdl/i2c_master_bit_engine.sv
// I2C master bit engine, bit-banged, MSB first.
// req channel: one beat per item, either a tick carrying the sampled SDA level
// (mode tick) or a command (start, stop, write byte, read byte, wait ack).
// Commands that arrive while a command is running are dropped; ticks step the
// running command, each line change being half_period_ticks ticks apart.
// rsp channel: exactly one beat per req beat, in order, with the SCL/SDA
// levels, SDA drive enable, busy, done pulse, last received byte and the
// ack timeout flag as they stand after that item.
// csr port: index 0 half_period_ticks, index 1 ack_timeout_ticks; write only
// while no beat is in flight.
// Results are registered into the rsp register; the whole update of the
// line sequencer sits between the state registers and the rsp register, so
// one item is taken every cycle while req_stall is low.
// When rsp_stall holds, one more req beat is taken into a skid register and
// req_stall then rises until that beat moves on into the rsp register.
// Reset (synchronous, active high) puts the lines at SCL high, SDA high driven,
// idle, and loads the register defaults 4 and 250.
module i2c_master_bit_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_mode,
   input  logic [7:0]                    req_tx_byte,
   input  logic                          req_ack_to_send,
   input  logic                          req_sda_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_scl_level,
   output logic                          rsp_sda_level,
   output logic                          rsp_sda_drive,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic [7:0]                    rsp_rx_byte,
   output logic                          rsp_ack_error,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [i2cm_pkg::CfgWidth-1:0] csr_wdata
);
   import i2cm_pkg::*;

   logic [CfgWidth-1:0] half_period_ff;
   logic [CfgWidth-1:0] ack_timeout_ff;
   logic                accept;
   result_type          step_result;
   result_type          rsp_data;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata;
            CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata;
            default:         half_period_ff <= half_period_ff;
         endcase
      end
   end

   i2cm_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .mode              (req_mode),
      .tx_byte           (req_tx_byte),
      .ack_to_send       (req_ack_to_send),
      .sda_sample        (req_sda_sample),
      .half_period_ticks (half_period_ff),
      .ack_timeout_ticks (ack_timeout_ff),
      .result            (step_result)
   );

   i2cm_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (step_result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_scl_level = rsp_data.scl_level;
   assign rsp_sda_level = rsp_data.sda_level;
   assign rsp_sda_drive = rsp_data.sda_drive;
   assign rsp_busy_res  = rsp_data.busy_res;
   assign rsp_done_res  = rsp_data.done_res;
   assign rsp_rx_byte   = rsp_data.rx_byte;
   assign rsp_ack_error = rsp_data.ack_error;

endmodule
